/* src/rpp_pkg.sv */
// shared types, constants and tables for the pivot rotation unit
`default_nettype none
package rpp_pkg;

   localparam int COORD_W     = 32;
   localparam int ANGLE_W     = 16;
   localparam int TRIG_STAGES = 16;
   localparam int TRIG_W      = 34;
   localparam int ZW          = 32;
   localparam int Q30_W       = 32;
   localparam int PROD_A_W    = COORD_W + 1 + 17;
   localparam int PROD_B_W    = COORD_W + 1 + 16;
   localparam int RND_W       = COORD_W + 6;

   localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
   localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
   localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
   localparam logic signed [Q30_W-1:0]  ONE_Q30      = 32'sd1073741824;
   localparam logic signed [TRIG_W-1:0] GAIN_INV_Q30 = 34'sd652032874;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_Z = 3'd5;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] rotated_x;
      logic signed [COORD_W-1:0] rotated_y;
      logic signed [COORD_W-1:0] rotated_z;
   } rsp_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [ZW-1:0]     z;
      logic zero;
      logic qpos;
      logic qneg;
      logic neg;
   } trig_lane_type;

   typedef struct packed {
      req_type             pt;
      trig_lane_type [2:0] lane;
   } cordic_item_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [2:0][Q30_W-1:0] cos_q;
      logic [2:0][Q30_W-1:0] sin_q;
   } work_type;

   // atan(2^-i) in 2^-20 degree units
   function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
      logic signed [ZW-1:0] r;
      case (i)
         5'd0:  r = 32'sd47185920;
         5'd1:  r = 32'sd27855475;
         5'd2:  r = 32'sd14718068;
         5'd3:  r = 32'sd7471121;
         5'd4:  r = 32'sd3750058;
         5'd5:  r = 32'sd1876857;
         5'd6:  r = 32'sd938658;
         5'd7:  r = 32'sd469357;
         5'd8:  r = 32'sd234682;
         5'd9:  r = 32'sd117342;
         5'd10: r = 32'sd58671;
         5'd11: r = 32'sd29335;
         5'd12: r = 32'sd14668;
         5'd13: r = 32'sd7334;
         5'd14: r = 32'sd3667;
         5'd15: r = 32'sd1833;
         5'd16: r = 32'sd917;
         5'd17: r = 32'sd458;
         5'd18: r = 32'sd229;
         5'd19: r = 32'sd115;
         5'd20: r = 32'sd57;
         5'd21: r = 32'sd29;
         5'd22: r = 32'sd14;
         5'd23: r = 32'sd7;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* src/euler_rotate_point_about_pivot_unit.sv */
// Rotates a stream of Q16.16 points about a configured pivot, X then Y then Z.
// Input beats arrive on req_valid/req_stall with a req_type payload, results leave on
// rsp_valid/rsp_stall with a rsp_type payload, one result beat per input beat, in order.
// Angles (degrees*64) and pivot coordinates are written through the csr_ port, which is
// always ready; write it only while no beat is in flight.
// Sine and cosine come from a row of 16 cordic cells that each point travels through
// with its three angle lanes, followed by a trig finish stage and three axis stages of
// two registers each (partial products, then round and saturate).
// Each beat passes a prep register, the cordic cells, trig finish and the axis stages.
// Throughput is one beat per cycle while rsp_stall is low; each stage is a register with
// its own valid, so bubbles are squeezed out and input flows until the pipeline is full.
// When the receiver stalls, the result holds on rsp_ and req_stall rises only once
// every stage behind it holds a beat.
// Reset clears all valid bits and returns every angle and pivot register to zero.
`default_nettype none
module euler_rotate_point_about_pivot_unit
   import rpp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire req_type               req_data,
   output logic                       req_stall,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data,
   input  wire logic                  rsp_stall,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COORD_W-1:0]    csr_data,
   output logic                       csr_ready
);

   logic signed [ANGLE_W-1:0] angle_x_ff, angle_y_ff, angle_z_ff;
   logic signed [COORD_W-1:0] pivot_x_ff, pivot_y_ff, pivot_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_x_ff <= '0;
         angle_y_ff <= '0;
         angle_z_ff <= '0;
         pivot_x_ff <= '0;
         pivot_y_ff <= '0;
         pivot_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANGLE_X: angle_x_ff <= csr_data[ANGLE_W-1:0];
            CSR_ANGLE_Y: angle_y_ff <= csr_data[ANGLE_W-1:0];
            CSR_ANGLE_Z: angle_z_ff <= csr_data[ANGLE_W-1:0];
            CSR_PIVOT_X: pivot_x_ff <= csr_data;
            CSR_PIVOT_Y: pivot_y_ff <= csr_data;
            CSR_PIVOT_Z: pivot_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // angle reduction into [-90, 90] plus fold and quarter-turn flags
   function automatic trig_lane_type prep_lane(input logic signed [ANGLE_W-1:0] a);
      trig_lane_type l;
      logic signed [16:0] r;
      r = 17'(a);
      l.neg = 1'b0;
      if (r >= FULL_TURN) r = r - FULL_TURN;
      if (r <= -FULL_TURN) r = r + FULL_TURN;
      if (r > HALF_TURN) r = r - FULL_TURN;
      if (r < -HALF_TURN) r = r + FULL_TURN;
      if (r > QUARTER_TURN) begin
         r = r - HALF_TURN;
         l.neg = 1'b1;
      end else if (r < -QUARTER_TURN) begin
         r = r + HALF_TURN;
         l.neg = 1'b1;
      end
      l.zero = (r == 17'sd0);
      l.qpos = (r == QUARTER_TURN);
      l.qneg = (r == -QUARTER_TURN);
      l.x    = GAIN_INV_Q30;
      l.y    = '0;
      l.z    = ZW'(r) <<< 14;
      return l;
   endfunction

   // prep stage
   logic            v0_ff;
   cordic_item_type item0_ff;
   cordic_item_type item0_in;
   logic            ready0;

   logic            cell_valid [0:TRIG_STAGES];
   cordic_item_type cell_item  [0:TRIG_STAGES];
   logic            cell_ready [0:TRIG_STAGES];

   always_comb begin
      item0_in.pt      = req_data;
      item0_in.lane[0] = prep_lane(angle_x_ff);
      item0_in.lane[1] = prep_lane(angle_y_ff);
      item0_in.lane[2] = prep_lane(angle_z_ff);
   end

   assign ready0    = !v0_ff || cell_ready[0];
   assign req_stall = !ready0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (ready0) begin
         v0_ff <= req_valid;
      end
      if (ready0) begin
         item0_ff <= item0_in;
      end
   end

   assign cell_valid[0] = v0_ff;
   assign cell_item[0]  = item0_ff;

   for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
      rpp_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (5'(i)),
         .in_valid  (cell_valid[i]),
         .in_item   (cell_item[i]),
         .in_ready  (cell_ready[i]),
         .out_valid (cell_valid[i+1]),
         .out_item  (cell_item[i+1]),
         .out_ready (cell_ready[i+1])
      );
   end

   // trig finish: zero and quarter turns, clamp, fold sign
   logic     tv_ff;
   work_type titem_ff;
   work_type titem_in;
   logic     t_ready;
   logic     x_ready;

   function automatic logic signed [Q30_W-1:0] clamp1(input logic signed [TRIG_W-1:0] x);
      if (x > TRIG_W'(ONE_Q30)) return ONE_Q30;
      if (x < -TRIG_W'(ONE_Q30)) return -ONE_Q30;
      return x[Q30_W-1:0];
   endfunction

   always_comb begin
      logic signed [Q30_W-1:0] cv;
      logic signed [Q30_W-1:0] sv;
      titem_in.x = cell_item[TRIG_STAGES].pt.point_x;
      titem_in.y = cell_item[TRIG_STAGES].pt.point_y;
      titem_in.z = cell_item[TRIG_STAGES].pt.point_z;
      for (int k = 0; k < 3; k++) begin
         if (cell_item[TRIG_STAGES].lane[k].zero) begin
            cv = ONE_Q30;
            sv = '0;
         end else if (cell_item[TRIG_STAGES].lane[k].qpos) begin
            cv = '0;
            sv = ONE_Q30;
         end else if (cell_item[TRIG_STAGES].lane[k].qneg) begin
            cv = '0;
            sv = -ONE_Q30;
         end else begin
            cv = clamp1(cell_item[TRIG_STAGES].lane[k].x);
            sv = clamp1(cell_item[TRIG_STAGES].lane[k].y);
         end
         if (cell_item[TRIG_STAGES].lane[k].neg) begin
            cv = -cv;
            sv = -sv;
         end
         titem_in.cos_q[k] = cv;
         titem_in.sin_q[k] = sv;
      end
   end

   assign t_ready                 = !tv_ff || x_ready;
   assign cell_ready[TRIG_STAGES] = t_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else if (t_ready) begin
         tv_ff <= cell_valid[TRIG_STAGES];
      end
      if (t_ready) begin
         titem_ff <= titem_in;
      end
   end

   // about X: (y, z)
   logic     xv, y_ready, yv, z_ready, zv;
   work_type xitem, yitem, zitem;
   work_type xnext, ynext;
   logic signed [COORD_W-1:0] xu, xw, yu, yw, zu, zw;

   rpp_axis_turn u_turn_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tv_ff),
      .in_item   (titem_ff),
      .u         ($signed(titem_ff.y)),
      .v         ($signed(titem_ff.z)),
      .ou        (pivot_y_ff),
      .ov        (pivot_z_ff),
      .c         ($signed(titem_ff.cos_q[0])),
      .s         ($signed(titem_ff.sin_q[0])),
      .in_ready  (x_ready),
      .out_valid (xv),
      .out_item  (xitem),
      .out_u     (xu),
      .out_v     (xw),
      .out_ready (y_ready)
   );

   always_comb begin
      xnext   = xitem;
      xnext.y = xu;
      xnext.z = xw;
   end

   // about Y: (z, x)
   rpp_axis_turn u_turn_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xv),
      .in_item   (xnext),
      .u         ($signed(xnext.z)),
      .v         ($signed(xnext.x)),
      .ou        (pivot_z_ff),
      .ov        (pivot_x_ff),
      .c         ($signed(xnext.cos_q[1])),
      .s         ($signed(xnext.sin_q[1])),
      .in_ready  (y_ready),
      .out_valid (yv),
      .out_item  (yitem),
      .out_u     (yu),
      .out_v     (yw),
      .out_ready (z_ready)
   );

   always_comb begin
      ynext   = yitem;
      ynext.z = yu;
      ynext.x = yw;
   end

   // about Z: (x, y)
   rpp_axis_turn u_turn_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (yv),
      .in_item   (ynext),
      .u         ($signed(ynext.x)),
      .v         ($signed(ynext.y)),
      .ou        (pivot_x_ff),
      .ov        (pivot_y_ff),
      .c         ($signed(ynext.cos_q[2])),
      .s         ($signed(ynext.sin_q[2])),
      .in_ready  (z_ready),
      .out_valid (zv),
      .out_item  (zitem),
      .out_u     (zu),
      .out_v     (zw),
      .out_ready (!rsp_stall)
   );

   assign rsp_valid          = zv;
   assign rsp_data.rotated_x = zu;
   assign rsp_data.rotated_y = zw;
   assign rsp_data.rotated_z = $signed(zitem.z);

`ifndef SYNTHESIS
   // back-pressure only ever starts at the output
   a_stall_origin: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_stall && rsp_valid))
      else $error("input stalled without output stall");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      tv_ff |-> ($signed(titem_ff.cos_q[0]) <= ONE_Q30 &&
                 $signed(titem_ff.cos_q[0]) >= -ONE_Q30))
      else $error("cosine out of range");

   a_sin_range: assert property (@(posedge clock) disable iff (reset)
      tv_ff |-> ($signed(titem_ff.sin_q[2]) <= ONE_Q30 &&
                 $signed(titem_ff.sin_q[2]) >= -ONE_Q30))
      else $error("sine out of range");

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (v0_ff && item0_ff.lane[0].zero) |-> !item0_ff.lane[0].qpos && !item0_ff.lane[0].qneg)
      else $error("conflicting quarter-turn flags");
`endif

endmodule
`default_nettype wire

/* src/rpp_cordic_cell.sv */
// one cordic iteration for the three angle lanes, point carried alongside
`default_nettype none
module rpp_cordic_cell
   import rpp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [4:0]      stage_idx,
   input  wire logic            in_valid,
   input  wire cordic_item_type in_item,
   output logic                 in_ready,
   output logic                 out_valid,
   output cordic_item_type      out_item,
   input  wire logic            out_ready
);

   logic            valid_ff;
   cordic_item_type item_ff;
   cordic_item_type item_in;

   always_comb begin
      logic signed [TRIG_W-1:0] xs;
      logic signed [TRIG_W-1:0] ys;
      logic signed [ZW-1:0]     at;
      item_in = in_item;
      at = atan_val(stage_idx);
      for (int k = 0; k < 3; k++) begin
         xs = in_item.lane[k].x >>> stage_idx;
         ys = in_item.lane[k].y >>> stage_idx;
         if (in_item.lane[k].z >= 0) begin
            item_in.lane[k].x = in_item.lane[k].x - ys;
            item_in.lane[k].y = in_item.lane[k].y + xs;
            item_in.lane[k].z = in_item.lane[k].z - at;
         end else begin
            item_in.lane[k].x = in_item.lane[k].x + ys;
            item_in.lane[k].y = in_item.lane[k].y - xs;
            item_in.lane[k].z = in_item.lane[k].z + at;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

/* src/rpp_axis_turn.sv */
// rotation of one coordinate pair about the pivot: products, then round and saturate
`default_nettype none
module rpp_axis_turn
   import rpp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire work_type                  in_item,
   input  wire logic signed [COORD_W-1:0] u,
   input  wire logic signed [COORD_W-1:0] v,
   input  wire logic signed [COORD_W-1:0] ou,
   input  wire logic signed [COORD_W-1:0] ov,
   input  wire logic signed [Q30_W-1:0]   c,
   input  wire logic signed [Q30_W-1:0]   s,
   output logic                           in_ready,
   output logic                           out_valid,
   output work_type                       out_item,
   output logic signed [COORD_W-1:0]      out_u,
   output logic signed [COORD_W-1:0]      out_v,
   input  wire logic                      out_ready
);

   // product stage
   logic                         pv_ff;
   work_type                     pitem_ff;
   logic signed [COORD_W-1:0]    pou_ff, pov_ff;
   logic signed [PROD_A_W-1:0]   a_uc_ff, a_vs_ff, a_us_ff, a_vc_ff;
   logic signed [PROD_B_W-1:0]   b_uc_ff, b_vs_ff, b_us_ff, b_vc_ff;
   logic                         p_ready;

   // result stage
   logic                         rv_ff;
   work_type                     ritem_ff;
   logic signed [COORD_W-1:0]    ru_ff, rv_val_ff;
   logic signed [COORD_W-1:0]    ru_in, rv_val_in;

   logic signed [COORD_W:0] du, dv;
   logic signed [16:0]      ch, sh;
   logic signed [15:0]      cl, sl;

   function automatic logic signed [RND_W-1:0] rnd(input logic signed [PROD_A_W-1:0] a,
                                                   input logic signed [PROD_B_W-1:0] b);
      logic signed [PROD_A_W+18:0] t;
      t = (($bits(t))'(a) <<< 15) + ($bits(t))'(b) + (($bits(t))'(1) <<< 29);
      return RND_W'(t >>> 30);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat(input logic signed [RND_W+1:0] x);
      logic signed [RND_W+1:0] hi;
      logic signed [RND_W+1:0] lo;
      hi = ($bits(hi))'({1'b0, {(COORD_W-1){1'b1}}});
      lo = -hi - 1;
      if (x > hi) return hi[COORD_W-1:0];
      if (x < lo) return lo[COORD_W-1:0];
      return x[COORD_W-1:0];
   endfunction

   always_comb begin
      du = (COORD_W+1)'(u) - (COORD_W+1)'(ou);
      dv = (COORD_W+1)'(v) - (COORD_W+1)'(ov);
      ch = 17'(c >>> 15);
      sh = 17'(s >>> 15);
      cl = {1'b0, c[14:0]};
      sl = {1'b0, s[14:0]};
   end

   assign p_ready  = !rv_ff || out_ready;
   assign in_ready = !pv_ff || p_ready;

   always_comb begin
      ru_in     = sat((RND_W+2)'(pou_ff) + (RND_W+2)'(rnd(a_uc_ff, b_uc_ff))
                      - (RND_W+2)'(rnd(a_vs_ff, b_vs_ff)));
      rv_val_in = sat((RND_W+2)'(pov_ff) + (RND_W+2)'(rnd(a_us_ff, b_us_ff))
                      + (RND_W+2)'(rnd(a_vc_ff, b_vc_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            pv_ff <= in_valid;
         end
         if (p_ready) begin
            rv_ff <= pv_ff;
         end
      end
      if (in_ready) begin
         pitem_ff <= in_item;
         pou_ff   <= ou;
         pov_ff   <= ov;
         a_uc_ff  <= PROD_A_W'(du * ch);
         b_uc_ff  <= PROD_B_W'(du * cl);
         a_vs_ff  <= PROD_A_W'(dv * sh);
         b_vs_ff  <= PROD_B_W'(dv * sl);
         a_us_ff  <= PROD_A_W'(du * sh);
         b_us_ff  <= PROD_B_W'(du * sl);
         a_vc_ff  <= PROD_A_W'(dv * ch);
         b_vc_ff  <= PROD_B_W'(dv * cl);
      end
      if (p_ready) begin
         ritem_ff  <= pitem_ff;
         ru_ff     <= ru_in;
         rv_val_ff <= rv_val_in;
      end
   end

   assign out_valid = rv_ff;
   assign out_item  = ritem_ff;
   assign out_u     = ru_ff;
   assign out_v     = rv_val_ff;

endmodule
`default_nettype wire
